/* design/skct_pkg.sv */
// shared constants and types for the sorted key count table
package skct_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 20;
    localparam int FREQ_W       = 31;
    localparam int OUT_TDATA_W  = 40;

    // output beat layout
    localparam int OUT_FOUND_LSB  = 0;
    localparam int OUT_FREQ_LSB   = 1;
    localparam int OUT_STATUS_LSB = OUT_FREQ_LSB + FREQ_W;

    // request kinds carried on tuser
    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic collect;  // shift the match accumulator one cell along
        logic update;   // commit the request to the table
        logic is_put;
        logic hit;      // key present somewhere in the row
        logic full;     // last cell occupied
    } t_cell_cmd;

endpackage

/* design/skct_cell.sv */
// one table slot: key, frequency, occupancy and a match accumulator stage
module skct_cell #(
    parameter int KEY_BITS = skct_pkg::KEY_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  skct_pkg::t_cell_cmd       i_cmd,
    input  logic [KEY_BITS-1:0]       i_key,
    input  logic [skct_pkg::FREQ_W-1:0] i_freq,
    input  logic [KEY_BITS-1:0]       i_left_key,
    input  logic [skct_pkg::FREQ_W-1:0] i_left_freq,
    input  logic                      i_left_valid,
    input  logic                      i_left_lt,
    input  logic                      i_left_acc_hit,
    input  logic [skct_pkg::FREQ_W-1:0] i_left_acc_freq,
    output logic [KEY_BITS-1:0]       o_key,
    output logic [skct_pkg::FREQ_W-1:0] o_freq,
    output logic                      o_valid,
    output logic                      o_lt,
    output logic                      o_acc_hit,
    output logic [skct_pkg::FREQ_W-1:0] o_acc_freq
);

    logic [KEY_BITS-1:0]         r_key;
    logic [skct_pkg::FREQ_W-1:0] r_freq;
    logic                        r_valid;
    logic                        r_acc_hit;
    logic [skct_pkg::FREQ_W-1:0] r_acc_freq;
    logic                        w_eq;
    logic                        w_lt;

    assign w_eq = r_valid && (r_key == i_key);
    assign w_lt = r_valid && (r_key < i_key);

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.update && i_cmd.is_put && !i_cmd.hit && !i_cmd.full && !w_lt) begin
            r_valid <= i_left_lt ? 1'b1 : i_left_valid;
        end
    end

    // slot contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && i_cmd.is_put) begin
            if (i_cmd.hit) begin
                if (w_eq) begin
                    r_freq <= i_freq;
                end
            end else if (!i_cmd.full && !w_lt) begin
                if (i_left_lt) begin
                    r_key  <= i_key;
                    r_freq <= i_freq;
                end else begin
                    r_key  <= i_left_key;
                    r_freq <= i_left_freq;
                end
            end
        end
    end

    // match accumulator, one cell further each cycle while collecting
    always_ff @(posedge i_clk) begin
        if (i_cmd.collect) begin
            r_acc_hit  <= i_left_acc_hit | w_eq;
            r_acc_freq <= i_left_acc_freq | (w_eq ? r_freq : '0);
        end
    end

    assign o_key      = r_key;
    assign o_freq     = r_freq;
    assign o_valid    = r_valid;
    assign o_lt       = w_lt;
    assign o_acc_hit  = r_acc_hit;
    assign o_acc_freq = r_acc_freq;

endmodule

/* design/sorted_key_count_table.sv */
// sorted key count table: a row of slot cells kept in ascending key order
//
//  channel | dir | tdata (lsb first)                    | tuser
//  s       | in  | key, freq_value, zero pad            | req_type (0 put, 1 get)
//  m       | out | found, freq_out, status, zero pad    | none
//
// each request is accepted, then the match accumulator ripples down the
// cell row while collecting, then the request commits and loads the result beat
// an insert shifts every larger slot one cell up in the commit cycle
// reset (i_rst_n low, synchronous) empties the table and drops any pending beat
// a stalled result beat holds the commit cycle; the next request is accepted
// while a finished beat still waits on the master side
module sorted_key_count_table #(
    parameter int CAPACITY = skct_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = skct_pkg::KEY_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // key, freq_value, zero pad
    input  logic [((KEY_BITS+skct_pkg::FREQ_W+7)/8)*8-1:0] i_s_tdata,
    // req_type
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // found, freq_out, status, zero pad
    output logic [skct_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int FW     = skct_pkg::FREQ_W;
    localparam int CNT_W  = $clog2(CAPACITY);

    // sequencer states
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COLLECT = 2'd1;
    localparam logic [1:0] ST_UPDATE  = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_is_get;
    logic [KEY_BITS-1:0] r_key;
    logic [FW-1:0]       r_freq;
    logic                r_out_valid;
    logic [skct_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [skct_pkg::OUT_TDATA_W-1:0] n_out_data;

    logic                s_beat;
    logic                w_fire;
    skct_pkg::t_cell_cmd w_cmd;

    // cell row wiring, index is the slot
    logic [KEY_BITS-1:0] w_key      [CAPACITY];
    logic [FW-1:0]       w_freq     [CAPACITY];
    logic                w_valid    [CAPACITY];
    logic                w_lt       [CAPACITY];
    logic                w_acc_hit  [CAPACITY];
    logic [FW-1:0]       w_acc_freq [CAPACITY];

    logic w_hit;
    logic w_full;

    assign s_beat     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    // commit only when the output register can take the beat
    assign w_fire     = (r_state == ST_UPDATE) && (!r_out_valid || i_m_tready);

    // the last accumulator stage sees the whole row once collection ends
    assign w_hit  = w_acc_hit[CAPACITY-1];
    assign w_full = w_valid[CAPACITY-1];

    assign w_cmd.collect = (r_state == ST_COLLECT);
    assign w_cmd.update  = w_fire;
    assign w_cmd.is_put  = (r_is_get == skct_pkg::REQ_PUT);
    assign w_cmd.hit     = w_hit;
    assign w_cmd.full    = w_full;

    // request capture
    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_is_get <= i_s_tuser;
            r_key    <= i_s_tdata[KEY_BITS-1:0];
            r_freq   <= i_s_tdata[KEY_BITS+FW-1:KEY_BITS];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_beat) begin
                    n_state = ST_COLLECT;
                end
            end
            ST_COLLECT: begin
                if (r_cnt == CNT_W'(CAPACITY - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_COLLECT) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // output register, parts the two sides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out_data = '0;
        n_out_data[skct_pkg::OUT_FOUND_LSB] = w_hit;
        // frequency only on a get that hits
        n_out_data[skct_pkg::OUT_FREQ_LSB +: FW] =
            (!w_cmd.is_put && w_hit) ? w_acc_freq[CAPACITY-1] : '0;
        // refused insert of a new key into a full table
        n_out_data[skct_pkg::OUT_STATUS_LSB] =
            (w_cmd.is_put && !w_hit && w_full) ? skct_pkg::STATUS_FULL
                                               : skct_pkg::STATUS_OK;
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // the cell row; slot zero sees a virtual left neighbour that is smaller
    // than any key, so an insert at the front loads the new pair there
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_lkey;
        logic [FW-1:0]       w_lfreq;
        logic                w_lvalid;
        logic                w_llt;
        logic                w_lacc_hit;
        logic [FW-1:0]       w_lacc_freq;

        if (g == 0) begin : g_head
            assign w_lkey      = '0;
            assign w_lfreq     = '0;
            assign w_lvalid    = 1'b0;
            assign w_llt       = 1'b1;
            assign w_lacc_hit  = 1'b0;
            assign w_lacc_freq = '0;
        end else begin : g_body
            assign w_lkey      = w_key[g-1];
            assign w_lfreq     = w_freq[g-1];
            assign w_lvalid    = w_valid[g-1];
            assign w_llt       = w_lt[g-1];
            assign w_lacc_hit  = w_acc_hit[g-1];
            assign w_lacc_freq = w_acc_freq[g-1];
        end

        skct_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_cmd           (w_cmd),
            .i_key           (r_key),
            .i_freq          (r_freq),
            .i_left_key      (w_lkey),
            .i_left_freq     (w_lfreq),
            .i_left_valid    (w_lvalid),
            .i_left_lt       (w_llt),
            .i_left_acc_hit  (w_lacc_hit),
            .i_left_acc_freq (w_lacc_freq),
            .o_key           (w_key[g]),
            .o_freq          (w_freq[g]),
            .o_valid         (w_valid[g]),
            .o_lt            (w_lt[g]),
            .o_acc_hit       (w_acc_hit[g]),
            .o_acc_freq      (w_acc_freq[g])
        );
    end

endmodule

/* design/skct_checker.sv */
// port level checks for the sorted key count table, bound to the top level
module skct_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_tvalid,
    input logic                                 o_s_tready,
    input logic                                 o_m_tvalid,
    input logic                                 i_m_tready,
    input logic [skct_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int FW = skct_pkg::FREQ_W;

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat withdrawn while stalled");

    // one request in flight: no second beat taken right after one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while previous still in work");

    // a refused insert never reports a present key
    a_status_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[skct_pkg::OUT_FOUND_LSB] &&
                         o_m_tdata[skct_pkg::OUT_STATUS_LSB]))
        else $error("found and table full both set");

    // a non-zero frequency only comes with a hit
    a_freq_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[skct_pkg::OUT_FREQ_LSB +: FW] != '0)
        |-> o_m_tdata[skct_pkg::OUT_FOUND_LSB])
        else $error("frequency returned without a hit");

endmodule

bind sorted_key_count_table skct_checker u_skct_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
